>>> rtl/core/ramp_plateau_pulse_pattern_generator_assert.svh
// ----------------------------------------------------------------------------
// assertion macros for the ramp plateau pulse pattern generator
// clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef RAMP_PLATEAU_PULSE_PATTERN_GENERATOR_ASSERT_SVH
`define RAMP_PLATEAU_PULSE_PATTERN_GENERATOR_ASSERT_SVH

// condition holds at every edge out of reset
`define RPPG_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("rppg: invariant violated");

// consequent holds in the cycle after the antecedent
`define RPPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rppg: sequence violated");

`endif

>>> rtl/core/rppg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rppg_pkg
// types, constants and helper functions of the pulse pattern generator
// ----------------------------------------------------------------------------
package rppg_pkg;

    localparam logic [7:0] AMP_MAX      = 8'd239;
    localparam logic [7:0] AMP_MIN      = 8'd16;
    localparam logic [7:0] OFFSET_DELTA = 8'd2;
    localparam logic [7:0] OFFSET_START = 8'd1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DUR_HI        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUR_LO        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_HI       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LO       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEPS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PLATEAU_STEPS = 3'd6;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    localparam logic [2:0] PAIR_HI      = 3'd0;
    localparam logic [2:0] PAIR_HI_OFF  = 3'd1;
    localparam logic [2:0] PAIR_HI_END  = 3'd2;
    localparam logic [2:0] PAIR_LO      = 3'd3;
    localparam logic [2:0] PAIR_LO_OFF  = 3'd4;
    localparam logic [2:0] PAIR_LAST    = 3'd5;

    localparam int SETTLE_PASSES = 4;

    typedef enum logic [1:0] {
        PH_RISE    = 2'd0,
        PH_PLATEAU = 2'd1,
        PH_FALL    = 2'd2
    } t_phase;

    typedef struct packed {
        logic        running;
        logic [15:0] reps;
        t_phase      phase;
        logic [15:0] steps;
    } t_seq;

    function automatic logic [7:0] amp_up(input logic [7:0] amp, input logic [7:0] step);
        logic [8:0] sum;
        sum = {1'b0, amp} + {1'b0, step};
        if (sum > {1'b0, AMP_MAX}) begin
            return AMP_MAX;
        end
        return sum[7:0];
    endfunction

    function automatic logic [7:0] amp_down(input logic [7:0] amp, input logic [7:0] step);
        logic [8:0] floor_v;
        floor_v = {1'b0, step} + {1'b0, AMP_MIN};
        if ({1'b0, amp} < floor_v) begin
            return AMP_MIN;
        end
        return amp - step;
    endfunction

    // advance to the next step that emits pairs, or go idle
    function automatic t_seq settle(input t_seq cur, input logic [15:0] ramp,
                                    input logic [15:0] plat);
        t_seq s;
        logic done;
        s    = cur;
        done = 1'b0;
        if (ramp == 16'd0 && plat == 16'd0) begin
            s.running = 1'b0;
        end
        for (int i = 0; i < SETTLE_PASSES; i++) begin
            if (s.running && !done) begin
                if (s.reps == 16'd0) begin
                    s.running = 1'b0;
                end else if (s.steps != 16'd0) begin
                    done = 1'b1;
                end else begin
                    case (s.phase)
                        PH_RISE: begin
                            s.phase = PH_PLATEAU;
                            s.steps = plat;
                        end
                        PH_PLATEAU: begin
                            s.phase = PH_FALL;
                            s.steps = ramp;
                        end
                        default: begin
                            s.reps  = s.reps - 16'd1;
                            s.phase = PH_RISE;
                            s.steps = ramp;
                        end
                    endcase
                end
            end
        end
        return s;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/ramp_plateau_pulse_pattern_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ramp_plateau_pulse_pattern_generator
// stages: an accepted beat is held in the input register; the pair of a next
// command is then registered in the output register that drives the master side
// throughput: one beat per cycle unless m_tready stalls; the add and clamp
// of the amplitude step and the step sequencer sit between the input and the result register
// reset: synchronous active low; pattern idle, amplitudes zero, offsets one,
// all configuration registers zero
// ----------------------------------------------------------------------------
`include "ramp_plateau_pulse_pattern_generator_assert.svh"

module ramp_plateau_pulse_pattern_generator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // config write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [rppg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rppg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // command stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [15:0]                     s_tdata,  // start_amp_hi, start_amp_lo
    input  wire logic                            s_tuser,  // cmd
    // pair stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [15:0]                          m_tdata,  // amplitude, duration
    output logic                                 m_tlast
);
    import rppg_pkg::*;

    logic [7:0]  r_dur_hi, r_dur_lo, r_step_hi, r_step_lo;
    logic [15:0] r_repeat_count, r_ramp_steps, r_plateau_steps;

    logic        r_in_valid;
    logic        r_in_cmd;
    logic [7:0]  r_in_hi, r_in_lo;

    logic [7:0]  r_amp_hi, r_amp_lo, r_off_hi, r_off_lo;
    logic [15:0] r_reps, r_steps;
    t_phase      r_phase;
    logic [2:0]  r_pair;
    logic        r_running;

    logic [7:0]  n_amp_hi, n_amp_lo, n_off_hi, n_off_lo;
    logic [15:0] n_reps, n_steps;
    t_phase      n_phase;
    logic [2:0]  n_pair;
    logic        n_running;

    logic        r_out_valid;
    logic [7:0]  r_out_amp, r_out_dur;
    logic        r_out_last;
    logic [7:0]  n_out_amp, n_out_dur;
    logic        n_out_last;

    logic        advance;
    logic        emit;
    logic [7:0]  cur_hi, cur_lo;
    t_seq        seq_in, seq_out;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready    = !r_in_valid || advance;
    assign m_tvalid    = r_out_valid;
    assign m_tdata     = {r_out_dur, r_out_amp};
    assign m_tlast     = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur_hi        <= '0;
            r_dur_lo        <= '0;
            r_step_hi       <= '0;
            r_step_lo       <= '0;
            r_repeat_count  <= '0;
            r_ramp_steps    <= '0;
            r_plateau_steps <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DUR_HI:        r_dur_hi        <= i_cfg_data[7:0];
                CFG_DUR_LO:        r_dur_lo        <= i_cfg_data[7:0];
                CFG_STEP_HI:       r_step_hi       <= i_cfg_data[7:0];
                CFG_STEP_LO:       r_step_lo       <= i_cfg_data[7:0];
                CFG_REPEAT_COUNT:  r_repeat_count  <= i_cfg_data;
                CFG_RAMP_STEPS:    r_ramp_steps    <= i_cfg_data;
                CFG_PLATEAU_STEPS: r_plateau_steps <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // step sequencer, amplitude update and pair select
    always_comb begin
        n_amp_hi   = r_amp_hi;
        n_amp_lo   = r_amp_lo;
        n_off_hi   = r_off_hi;
        n_off_lo   = r_off_lo;
        n_reps     = r_reps;
        n_steps    = r_steps;
        n_phase    = r_phase;
        n_pair     = r_pair;
        n_running  = r_running;
        n_out_amp  = r_out_amp;
        n_out_dur  = r_out_dur;
        n_out_last = r_out_last;
        emit       = 1'b0;
        cur_hi     = r_amp_hi;
        cur_lo     = r_amp_lo;
        seq_in     = '{running: 1'b1, reps: r_reps, phase: r_phase, steps: r_steps};

        if (r_in_cmd == CMD_START) begin
            seq_in = '{running: 1'b1, reps: r_repeat_count, phase: PH_RISE,
                       steps: r_ramp_steps};
        end else if (r_pair == PAIR_LAST) begin
            seq_in.steps = r_steps - 16'd1;
        end
        seq_out = settle(seq_in, r_ramp_steps, r_plateau_steps);

        if (r_pair == PAIR_HI && r_phase == PH_RISE) begin
            cur_hi = amp_up(r_amp_hi, r_step_hi);
            cur_lo = amp_down(r_amp_lo, r_step_lo);
        end else if (r_pair == PAIR_HI && r_phase == PH_FALL) begin
            cur_hi = amp_down(r_amp_hi, r_step_hi);
            cur_lo = amp_up(r_amp_lo, r_step_lo);
        end

        if (advance) begin
            if (r_in_cmd == CMD_START) begin
                n_amp_hi  = r_in_hi;
                n_amp_lo  = r_in_lo;
                n_off_hi  = OFFSET_START;
                n_off_lo  = OFFSET_START;
                n_pair    = PAIR_HI;
                n_running = seq_out.running;
                n_reps    = seq_out.reps;
                n_phase   = seq_out.phase;
                n_steps   = seq_out.steps;
            end else if (r_running) begin
                emit = 1'b1;
                if (r_pair == PAIR_HI && r_phase != PH_PLATEAU) begin
                    n_amp_hi = cur_hi;
                    n_amp_lo = cur_lo;
                    n_off_hi = cur_hi - OFFSET_DELTA;
                    n_off_lo = cur_lo + OFFSET_DELTA;
                end
                case (r_pair)
                    PAIR_HI, PAIR_HI_END: begin
                        n_out_amp = cur_hi;
                        n_out_dur = r_dur_hi;
                    end
                    PAIR_HI_OFF: begin
                        n_out_amp = r_off_hi;
                        n_out_dur = r_dur_hi;
                    end
                    PAIR_LO, PAIR_LAST: begin
                        n_out_amp = r_amp_lo;
                        n_out_dur = r_dur_lo;
                    end
                    default: begin
                        n_out_amp = r_off_lo;
                        n_out_dur = r_dur_lo;
                    end
                endcase
                if (r_pair == PAIR_LAST) begin
                    n_pair     = PAIR_HI;
                    n_running  = seq_out.running;
                    n_reps     = seq_out.reps;
                    n_phase    = seq_out.phase;
                    n_steps    = seq_out.steps;
                    n_out_last = !seq_out.running;
                end else begin
                    n_pair     = r_pair + 3'd1;
                    n_out_last = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_amp_hi    <= '0;
            r_amp_lo    <= '0;
            r_off_hi    <= OFFSET_START;
            r_off_lo    <= OFFSET_START;
            r_reps      <= '0;
            r_steps     <= '0;
            r_phase     <= PH_RISE;
            r_pair      <= PAIR_HI;
            r_running   <= 1'b0;
        end else begin
            if (s_tready) begin
                r_in_valid <= s_tvalid;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
            r_amp_hi  <= n_amp_hi;
            r_amp_lo  <= n_amp_lo;
            r_off_hi  <= n_off_hi;
            r_off_lo  <= n_off_lo;
            r_reps    <= n_reps;
            r_steps   <= n_steps;
            r_phase   <= n_phase;
            r_pair    <= n_pair;
            r_running <= n_running;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_cmd <= s_tuser;
            r_in_hi  <= s_tdata[7:0];
            r_in_lo  <= s_tdata[15:8];
        end
        if (emit) begin
            r_out_amp  <= n_out_amp;
            r_out_dur  <= n_out_dur;
            r_out_last <= n_out_last;
        end
    end

    `RPPG_ASSERT_ALWAYS(a_pair_range, r_pair <= PAIR_LAST)
    `RPPG_ASSERT_ALWAYS(a_run_has_work, !r_running || (r_steps != 16'd0 && r_reps != 16'd0))
    `RPPG_ASSERT_ALWAYS(a_idle_pair_zero, r_running || r_pair == PAIR_HI)
    `RPPG_ASSERT_NEXT(a_start_restarts, advance && r_in_cmd == CMD_START, r_pair == PAIR_HI && !r_out_valid)

endmodule
`default_nettype wire
